// ----- rtl/otb_pkg.sv -----
// ----------------------------------------------------------------------------
// otb_pkg
// shared widths, codes and types of the one-shot timer bank
// ----------------------------------------------------------------------------
package otb_pkg;

	// field widths
	localparam int unsigned OP_W   = 3;
	localparam int unsigned ID_W   = 4;
	localparam int unsigned TICK_W = 31;
	localparam int unsigned TAG_W  = 32;
	localparam int unsigned KIND_W = 2;

	// slot count limits
	localparam int unsigned SLOTS_DEF = 16;
	localparam int unsigned SLOTS_CAP = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
	localparam logic [OP_W-1:0] OP_START  = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd3;

	typedef enum logic [1:0] {
		MODE_FREE,
		MODE_IDLE,
		MODE_RUN
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [ID_W-1:0]         slot;
		logic                    ok;
		logic signed [TAG_W-1:0] event_tag_a;
		logic signed [TAG_W-1:0] event_tag_b;
		logic                    last;
	} rsp_t;

endpackage

// ----- rtl/otb_req_if.sv -----
// ----------------------------------------------------------------------------
// otb_req_if
// request channel of the timer bank: one operation per transfer
// ----------------------------------------------------------------------------
interface otb_req_if import otb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic [ID_W-1:0]         timer_id;
	logic [TICK_W-1:0]       count;
	logic signed [TAG_W-1:0] tag_a;
	logic signed [TAG_W-1:0] tag_b;
	logic                    notify;

	modport source (
		output valid, op, timer_id, count, tag_a, tag_b, notify,
		input  ready
	);

	modport sink (
		input  valid, op, timer_id, count, tag_a, tag_b, notify,
		output ready
	);
endinterface

// ----- rtl/otb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// otb_rsp_if
// result channel of the timer bank: one result per transfer
// ----------------------------------------------------------------------------
interface otb_rsp_if import otb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [ID_W-1:0]         slot;
	logic                    ok;
	logic signed [TAG_W-1:0] event_tag_a;
	logic signed [TAG_W-1:0] event_tag_b;
	logic                    last;

	modport source (
		output valid, kind, slot, ok, event_tag_a, event_tag_b, last,
		input  ready
	);

	modport sink (
		input  valid, kind, slot, ok, event_tag_a, event_tag_b, last,
		output ready
	);
endinterface

// ----- rtl/one_shot_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_bank_unit
// bank of one-shot timer slots with create, delete, cancel, start and tick
// ----------------------------------------------------------------------------
// usage
//   req carries one operation per transfer, rsp returns its results, the
//   final one of each operation marked by last
//   create, delete, cancel, start and unknown ops are answered by one result
//   registered at the accepting edge, so it appears in the next cycle
//   a tick walks the slots one per cycle, while the walk is not paused,
//   through a single decrement and compare unit: the walk visits every slot
//   in ST_SCAN and closes in ST_FLUSH, then req is ready again; expiry
//   events leave in slot order
//   the last expiry (or the quiet result when nothing fires) is held back
//   until the walk ends so that it can carry last
//   when the receiver stalls the output register holds its result; the walk
//   pauses on a slot whose event would displace a held one into a still
//   full output register; req stays low until the register can take a result
//   reset frees every slot and empties the output register
// ----------------------------------------------------------------------------
module one_shot_timer_bank_unit import otb_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	otb_req_if.sink   req,
	otb_rsp_if.source rsp
);

	// the slot index is four bits wide, so the bank holds at most sixteen
	localparam int unsigned NSLOT = (SLOTS < SLOTS_CAP) ? SLOTS : SLOTS_CAP;
	localparam int unsigned IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NSLOT - 1);
	localparam logic [ID_W:0] NSLOT_ID = (ID_W + 1)'(NSLOT);

	// control state
	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	mode_t            mode_q [NSLOT];
	logic             pend_valid_q;
	logic             rsp_valid_q;

	// slot payload, only meaningful while a slot runs
	logic [TICK_W-1:0]       ticks_q  [NSLOT];
	logic signed [TAG_W-1:0] tag_a_q  [NSLOT];
	logic signed [TAG_W-1:0] tag_b_q  [NSLOT];
	logic                    notify_q [NSLOT];

	// expiry held back until the walk knows whether it is the last
	logic [IDX_W-1:0]        pend_slot_q;
	logic signed [TAG_W-1:0] pend_ta_q;
	logic signed [TAG_W-1:0] pend_tb_q;

	rsp_t rsp_q;

	// handshake and sequencer controls
	logic out_free;
	logic req_ready;
	logic accept;
	logic scan_go;
	logic push;
	rsp_t push_data;

	// shared decrement and compare unit on the visited slot
	mode_t             cur_mode;
	logic [TICK_W-1:0] cur_ticks;
	logic [TICK_W-1:0] cur_dec;
	logic              cur_expire;
	logic              cur_event;

	// request decode
	logic             id_ok;
	logic [IDX_W-1:0] id_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	assign out_free   = !rsp_valid_q || rsp.ready;
	assign accept     = req.valid && req_ready;

	assign cur_mode   = mode_q[idx_q];
	assign cur_ticks  = ticks_q[idx_q];
	assign cur_dec    = cur_ticks - TICK_W'(1);
	// a count of zero fires like a count of one
	assign cur_expire = (cur_ticks[TICK_W-1:1] == '0);
	assign cur_event  = (cur_mode == MODE_RUN) && cur_expire && notify_q[idx_q];

	assign id_ok  = ({1'b0, req.timer_id} < NSLOT_ID);
	assign id_idx = req.timer_id[IDX_W-1:0];

	// lowest free slot for create
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mode_q[i] == MODE_FREE) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.op == OP_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_go && (idx_q == IDX_LAST)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		scan_go   = 1'b0;
		push      = 1'b0;
		push_data = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				if (req.valid && out_free && (req.op != OP_TICK)) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					if (req.op == OP_CREATE) begin
						push_data.kind = KIND_CREATE;
						push_data.ok   = free_found;
						push_data.slot = ID_W'(free_idx);
					end else begin
						push_data.kind = KIND_ACK;
					end
				end
			end
			ST_SCAN: begin
				// a new event displaces the held one, which then needs the output
				scan_go = !(cur_event && pend_valid_q && !out_free);
				if (scan_go && cur_event && pend_valid_q) begin
					push                  = 1'b1;
					push_data.kind        = KIND_EXPIRY;
					push_data.slot        = ID_W'(pend_slot_q);
					push_data.event_tag_a = pend_ta_q;
					push_data.event_tag_b = pend_tb_q;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					if (pend_valid_q) begin
						push_data.kind        = KIND_EXPIRY;
						push_data.slot        = ID_W'(pend_slot_q);
						push_data.event_tag_a = pend_ta_q;
						push_data.event_tag_b = pend_tb_q;
					end else begin
						push_data.kind = KIND_QUIET;
					end
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign req.ready = req_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			for (int i = 0; i < NSLOT; i++) begin
				mode_q[i] <= MODE_FREE;
			end
		end else begin
			state_q <= state_d;

			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (accept) begin
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
				case (req.op)
					OP_CREATE: begin
						if (free_found) begin
							mode_q[free_idx] <= MODE_IDLE;
						end
					end
					OP_DELETE: begin
						if (id_ok) begin
							mode_q[id_idx] <= MODE_FREE;
						end
					end
					OP_CANCEL: begin
						if (id_ok) begin
							mode_q[id_idx] <= MODE_IDLE;
						end
					end
					OP_START: begin
						if (id_ok) begin
							mode_q[id_idx] <= MODE_RUN;
						end
					end
					default: ;
				endcase
			end

			if (scan_go) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
				if ((cur_mode == MODE_RUN) && cur_expire) begin
					mode_q[idx_q] <= MODE_IDLE;
				end
				if (cur_event) begin
					pend_valid_q <= 1'b1;
				end
			end

			if ((state_q == ST_FLUSH) && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= push_data;
		end
		if (accept && (req.op == OP_START) && id_ok) begin
			ticks_q[id_idx]  <= req.count;
			tag_a_q[id_idx]  <= req.tag_a;
			tag_b_q[id_idx]  <= req.tag_b;
			notify_q[id_idx] <= req.notify;
		end
		if (scan_go && (cur_mode == MODE_RUN) && !cur_expire) begin
			ticks_q[idx_q] <= cur_dec;
		end
		if (scan_go && cur_event) begin
			pend_slot_q <= idx_q;
			pend_ta_q   <= tag_a_q[idx_q];
			pend_tb_q   <= tag_b_q[idx_q];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = rsp_q.kind;
	assign rsp.slot        = rsp_q.slot;
	assign rsp.ok          = rsp_q.ok;
	assign rsp.event_tag_a = rsp_q.event_tag_a;
	assign rsp.event_tag_b = rsp_q.event_tag_b;
	assign rsp.last        = rsp_q.last;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the one-shot timer bank: a directed table of
// operations, then a long random mix of create, start, cancel, delete and
// tick, each transfer checked against a cycle-free model of the slot bank
// ----------------------------------------------------------------------------
module tb_top import otb_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// bench sizing
	localparam int unsigned BANK_SLOTS   = SLOTS_DEF;
	localparam int unsigned LIVE_SLOTS   = (BANK_SLOTS < SLOTS_CAP) ? BANK_SLOTS : SLOTS_CAP;
	localparam int unsigned RANDOM_OPS   = 338;
	localparam int unsigned TAIL_CYCLES  = 2 * (SLOTS_CAP + 2) + 8;
	localparam int unsigned RUN_LIMIT_NS = 2_000_000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned MAX_REPORTS  = 10;

	// op codes outside the defined set, answered with a plain acknowledge
	localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
	localparam logic [TICK_W-1:0] TICK_MAX       = '1;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic [ID_W-1:0]         id;
		logic [TICK_W-1:0]       count;
		logic signed [TAG_W-1:0] tag_a;
		logic signed [TAG_W-1:0] tag_b;
		logic                    notify;
	} op_item_t;

	// one line of the directed table; walk steps the slot index over the repeats
	typedef struct {
		op_item_t    it;
		int unsigned reps;
		bit          walk;
		bit          typed;
		rsp_t        want;
	} plan_row_t;

	// a hand-written answer travels with its request until the request transfer
	typedef struct {
		bit   typed;
		rsp_t want;
	} verdict_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	otb_req_if req ();
	otb_rsp_if rsp ();

	one_shot_timer_bank_unit #(
		.SLOTS (BANK_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// model of the slot bank, advanced at every request transfer
	mode_t                   bank_mode   [SLOTS_CAP];
	logic [TICK_W-1:0]       bank_ticks  [SLOTS_CAP];
	logic signed [TAG_W-1:0] bank_tag_a  [SLOTS_CAP];
	logic signed [TAG_W-1:0] bank_tag_b  [SLOTS_CAP];
	logic                    bank_notify [SLOTS_CAP];

	rsp_t        bank_outcomes_q [$];   // results owed by the block, oldest first
	verdict_t    typed_answers   [$];
	plan_row_t   plan            [$];

	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned fault_count  = 0;
	int unsigned hold_left    = 0;
	bit          hold_done    = 1'b0;

	op_item_t    taken_item;
	verdict_t    taken_verdict;
	rsp_t        seen_rsp;
	rsp_t        head_rsp;

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// slot bank model
	// ------------------------------------------------------------------------

	function automatic void vacate(input int unsigned s, input mode_t m);
		bank_mode[s]   = m;
		bank_ticks[s]  = '0;
		bank_tag_a[s]  = '0;
		bank_tag_b[s]  = '0;
		bank_notify[s] = 1'b0;
	endfunction

	// works out the results of one operation and owes them to the checker;
	// a typed row replaces the worked-out answer with its own
	function automatic void bank_step(input op_item_t it, input bit typed, input rsp_t want);
		rsp_t fired [$];
		rsp_t r;
		bit   done;

		done = 1'b0;
		r    = '0;
		case (it.op)
			OP_TICK: begin
				// every running slot counts down, in index order
				for (int unsigned s = 0; s < LIVE_SLOTS; s++) begin
					if (bank_mode[s] == MODE_RUN) begin
						// a count of zero behaves like a count of one
						if (bank_ticks[s] <= TICK_W'(1)) begin
							bank_ticks[s] = '0;
							bank_mode[s]  = MODE_IDLE;
							if (bank_notify[s]) begin
								r             = '0;
								r.kind        = KIND_EXPIRY;
								r.slot        = ID_W'(s);
								r.event_tag_a = bank_tag_a[s];
								r.event_tag_b = bank_tag_b[s];
								fired.push_back(r);
							end
						end else begin
							bank_ticks[s] = bank_ticks[s] - TICK_W'(1);
						end
					end
				end
				if (fired.size() == 0) begin
					r      = '0;
					r.kind = KIND_QUIET;
					fired.push_back(r);
				end
			end
			OP_CREATE: begin
				// lowest free slot, or ok low with slot 0 when the bank is full
				r.kind = KIND_CREATE;
				for (int unsigned s = 0; s < LIVE_SLOTS; s++) begin
					if (!done && bank_mode[s] == MODE_FREE) begin
						vacate(s, MODE_IDLE);
						r.slot = ID_W'(s);
						r.ok   = 1'b1;
						done   = 1'b1;
					end
				end
				fired.push_back(r);
			end
			default: begin
				// indexes beyond the bank and spare op codes change nothing
				if (it.id < LIVE_SLOTS) begin
					case (it.op)
						OP_DELETE: vacate(it.id, MODE_FREE);
						OP_CANCEL: vacate(it.id, MODE_IDLE);
						OP_START: begin
							bank_mode[it.id]   = MODE_RUN;
							bank_ticks[it.id]  = it.count;
							bank_tag_a[it.id]  = it.tag_a;
							bank_tag_b[it.id]  = it.tag_b;
							bank_notify[it.id] = it.notify;
						end
						default: ;
					endcase
				end
				r.kind = KIND_ACK;
				fired.push_back(r);
			end
		endcase
		fired[fired.size() - 1].last = 1'b1;

		if (typed) begin
			bank_outcomes_q.push_back(want);
		end else begin
			foreach (fired[k]) bank_outcomes_q.push_back(fired[k]);
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	function automatic void add_row(
		input logic [OP_W-1:0]   op,
		input int unsigned       id,
		input logic [TICK_W-1:0] count,
		input logic [TAG_W-1:0]  ta,
		input logic [TAG_W-1:0]  tb,
		input bit                nf,
		input int unsigned       reps,
		input bit                walk,
		input bit                typed,
		input logic [KIND_W-1:0] kind,
		input int unsigned       slot,
		input bit                ok
	);
		plan_row_t row;

		row.it.op     = op;
		row.it.id     = ID_W'(id);
		row.it.count  = count;
		row.it.tag_a  = ta;
		row.it.tag_b  = tb;
		row.it.notify = nf;
		row.reps      = reps;
		row.walk      = walk;
		row.typed     = typed;
		row.want      = '0;
		row.want.kind = kind;
		row.want.slot = ID_W'(slot);
		row.want.ok   = ok;
		row.want.last = 1'b1;
		plan.push_back(row);
	endfunction

	// random operation, aimed mostly at slots already in use so that starts
	// run to expiry and deletes keep slots coming back
	function automatic op_item_t draw_item();
		op_item_t    it;
		int unsigned held [$];
		int unsigned roll;
		int unsigned pick;

		for (int unsigned s = 0; s < LIVE_SLOTS; s++)
			if (bank_mode[s] != MODE_FREE) held.push_back(s);

		roll = $urandom_range(0, 99);
		if (roll < 30)      it.op = OP_TICK;
		else if (roll < 45) it.op = OP_CREATE;
		else if (roll < 72) it.op = OP_START;
		else if (roll < 80) it.op = OP_CANCEL;
		else if (roll < 95) it.op = OP_DELETE;
		else                it.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

		if (held.size() != 0 && $urandom_range(0, 3) != 0)
			it.id = ID_W'(held[$urandom_range(0, held.size() - 1)]);
		else
			it.id = ID_W'($urandom_range(0, SLOTS_CAP - 1));

		// short counts most of the time so that slots actually expire
		pick = $urandom_range(0, 9);
		if (pick < 7)      it.count = TICK_W'($urandom_range(0, 4));
		else if (pick < 9) it.count = TICK_W'($urandom_range(0, 40));
		else               it.count = TICK_W'($urandom());

		it.tag_a  = $urandom();
		it.tag_b  = $urandom();
		it.notify = ($urandom_range(0, 3) != 0);
		return it;
	endfunction

	// sender gaps, with a stretch of back-to-back transfers
	function automatic bit sender_pauses();
		if (items_sent >= 100 && items_sent < 180) return 1'b0;
		return ($urandom_range(0, 99) < 9);
	endfunction

	// offer one operation; entered and left at a falling edge
	task automatic offer(input op_item_t it, input bit typed, input rsp_t want);
		verdict_t v;

		while (sender_pauses()) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		v.typed = typed;
		v.want  = want;
		typed_answers.push_back(v);
		req.op       <= it.op;
		req.timer_id <= it.id;
		req.count    <= it.count;
		req.tag_a    <= it.tag_a;
		req.tag_b    <= it.tag_b;
		req.notify   <= it.notify;
		req.valid    <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	initial begin
		op_item_t it;
		rsp_t     none;

		none = '0;
		req.valid    = 1'b0;
		req.op       = OP_TICK;
		req.timer_id = '0;
		req.count    = '0;
		req.tag_a    = '0;
		req.tag_b    = '0;
		req.notify   = 1'b0;
		for (int unsigned s = 0; s < SLOTS_CAP; s++) vacate(s, MODE_FREE);

		// directed table
		//       op              id  count     tag_a         tag_b         nf reps walk typed kind         slot ok
		add_row(OP_TICK,         0,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_QUIET,  0,   0);
		add_row(OP_CREATE,       0,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_CREATE, 0,   1);
		add_row(OP_SPARE_FIRST,  15, TICK_MAX, '1,           '1,           1, 1,   0,   1,    KIND_ACK,    0,   0);
		add_row(OP_SPARE_LAST,   0,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_ACK,    0,   0);
		add_row(OP_CANCEL,       3,  TICK_MAX, 32'h1234_5678, 32'h9ABC_DEF0, 1, 1, 0,   1,    KIND_ACK,    0,   0);
		add_row(OP_START,        0,  '0,       32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0,   1,    KIND_ACK,    0,   0);
		add_row(OP_START,        1,  TICK_W'(1), 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 0, 1,    KIND_ACK,    0,   0);
		add_row(OP_START,        14, '0,       32'h0BAD_F00D, 32'h0000_0001, 0, 1, 0,   1,    KIND_ACK,    0,   0);
		add_row(OP_START,        2,  TICK_MAX, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 0,   1,    KIND_ACK,    0,   0);
		add_row(OP_TICK,         0,  '0,       '0,           '0,           0, 1,   0,   0,    KIND_ACK,    0,   0);
		add_row(OP_CANCEL,       2,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_ACK,    0,   0);
		add_row(OP_DELETE,       0,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_ACK,    0,   0);
		add_row(OP_CREATE,       0,  '0,       '0,           '0,           0, 1,   0,   0,    KIND_ACK,    0,   0);
		add_row(OP_START,        0,  TICK_W'(1), 32'h5A5A_0000, 32'hA5A5_FFFF, 1, 16, 1, 0,   KIND_ACK,    0,   0);
		add_row(OP_CREATE,       0,  '0,       '0,           '0,           0, 1,   0,   1,    KIND_CREATE, 0,   0);
		add_row(OP_TICK,         0,  '0,       '0,           '0,           0, 1,   0,   0,    KIND_ACK,    0,   0);
		add_row(OP_DELETE,       15, '0,       '0,           '0,           0, 1,   0,   1,    KIND_ACK,    0,   0);

		// hold reset, then release it on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			for (int unsigned r = 0; r < plan[i].reps; r++) begin
				it = plan[i].it;
				if (plan[i].walk) begin
					it.id    = ID_W'(r);
					it.tag_a = it.tag_a + r;
				end
				offer(it, plan[i].typed, plan[i].want);
			end
		end

		for (int unsigned n = 0; n < RANDOM_OPS; n++) offer(draw_item(), 1'b0, none);
		req.valid <= 1'b0;

		// drain, then a margin for anything the block should not send
		while (bank_outcomes_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, one long hold-off to back the block up, and a
	// stretch where every result is taken at once
	// ------------------------------------------------------------------------
	initial rsp.ready = 1'b0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= 120) begin
			rsp.ready <= 1'b0;
			hold_left = LONG_HOLD - 1;
			hold_done = 1'b1;
		end else if (results_seen >= 250 && results_seen < 330) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= 9);
		end
	end

	// ------------------------------------------------------------------------
	// checking, on the rising edge
	// ------------------------------------------------------------------------

	function automatic void report_fault(input string what, input rsp_t want, input rsp_t got);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t %0s: expected kind %0d slot %0d ok %0d tags %h %h last %0d",
				$realtime, what,
				want.kind, want.slot, want.ok, want.event_tag_a, want.event_tag_b, want.last,
				", got kind %0d slot %0d ok %0d tags %h %h last %0d",
				got.kind, got.slot, got.ok, got.event_tag_a, got.event_tag_b, got.last);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// request transfer: advance the model
			if (req.valid && req.ready) begin
				taken_item.op     = req.op;
				taken_item.id     = req.timer_id;
				taken_item.count  = req.count;
				taken_item.tag_a  = req.tag_a;
				taken_item.tag_b  = req.tag_b;
				taken_item.notify = req.notify;
				taken_verdict     = typed_answers.pop_front();
				bank_step(taken_item, taken_verdict.typed, taken_verdict.want);
			end
			// result transfer: compare against the oldest owed result
			if (rsp.valid && rsp.ready) begin
				seen_rsp.kind        = rsp.kind;
				seen_rsp.slot        = rsp.slot;
				seen_rsp.ok          = rsp.ok;
				seen_rsp.event_tag_a = rsp.event_tag_a;
				seen_rsp.event_tag_b = rsp.event_tag_b;
				seen_rsp.last        = rsp.last;
				results_seen++;
				if (bank_outcomes_q.size() == 0) begin
					report_fault("result with nothing owed", '0, seen_rsp);
				end else begin
					head_rsp = bank_outcomes_q.pop_front();
					if (seen_rsp.kind !== head_rsp.kind || seen_rsp.slot !== head_rsp.slot ||
					    seen_rsp.ok !== head_rsp.ok ||
					    seen_rsp.event_tag_a !== head_rsp.event_tag_a ||
					    seen_rsp.event_tag_b !== head_rsp.event_tag_b ||
					    seen_rsp.last !== head_rsp.last)
						report_fault("result mismatch", head_rsp, seen_rsp);
				end
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
